[rtl/core/rgbab_pkg.sv]
`default_nettype none

package rgbab_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned PixW   = 16;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned ChanW  = 6;
  localparam int unsigned WtW    = 8;
  localparam int unsigned ProdW  = ChanW + WtW;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [ModeW-1:0] MODE_OPAQUE = 3'd0;
  localparam logic [ModeW-1:0] MODE_ONE    = 3'd1;
  localparam logic [ModeW-1:0] MODE_TWO    = 3'd2;
  localparam logic [ModeW-1:0] MODE_FOUR   = 3'd3;
  localparam logic [ModeW-1:0] MODE_EIGHT  = 3'd4;

  localparam logic [AddrW-1:0] ADDR_ALPHA_MODE = 3'd0;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_3,
    DIV_15,
    DIV_255
  } div_sel_e;

  typedef struct packed {
    div_sel_e        div_sel;
    logic [WtW-1:0]  w_src;
    logic [WtW-1:0]  w_dst;
  } weight_t;

  // floor(x/3) for x <= 189
  function automatic logic [ChanW-1:0] div3(input logic [ProdW-1:0] x);
    logic [15:0] p;
    p = {8'd0, x[7:0]} * 16'd171;
    return p[14:9];
  endfunction

  // floor(x/15) for x <= 945
  function automatic logic [ChanW-1:0] div15(input logic [ProdW-1:0] x);
    logic [21:0] p;
    p = {12'd0, x[9:0]} * 22'd2185;
    return p[20:15];
  endfunction

  // floor(x/255) for x <= 16319
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ProdW-5){1'b0}}, x[ProdW-1:8]} + {{ProdW{1'b0}}, 1'b1};
    return t[13:8];
  endfunction

endpackage

`default_nettype wire

[rtl/core/rgb565_alpha_blend_pixel_top.sv]
`default_nettype none

// result_valid_o follows the start transfer through the input register and the result register.
// Throughput: one pixel per clock; busy stays low, start may be high every cycle.
// Input register, blend logic, result register; the result strobe lasts one cycle
// and the receiver cannot stall it.
// Reset: asynchronous, active low; clears the pipeline valid bits and sets
// alpha_mode to opaque copy.
module rgb565_alpha_blend_pixel_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbab_pkg::AddrW-1:0]  paddr,
  input  wire logic [rgbab_pkg::DataW-1:0]  pwdata,
  output logic      [rgbab_pkg::DataW-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [rgbab_pkg::PixW-1:0]   src_pixel_i,
  input  wire logic [rgbab_pkg::PixW-1:0]   dst_pixel_i,
  input  wire logic [rgbab_pkg::AlphaW-1:0] alpha_i,
  output logic                              result_valid_o,
  output logic      [rgbab_pkg::PixW-1:0]   out_pixel_o
);
  import rgbab_pkg::*;

  logic [ModeW-1:0]  alpha_mode;
  logic              in_vld_q;
  logic [PixW-1:0]   src_q, dst_q;
  logic [AlphaW-1:0] alpha_q;
  logic              out_vld_q;
  logic [PixW-1:0]   out_q, out_d;
  weight_t           wt;
  logic [ChanW-1:0]  c0, c1, c2;

  rgbab_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .alpha_mode_o (alpha_mode)
  );

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      src_q   <= src_pixel_i;
      dst_q   <= dst_pixel_i;
      alpha_q <= alpha_i;
    end
    if (in_vld_q) begin
      out_q <= out_d;
    end
  end

  // weights: w_src/D and w_dst/D with w_src + w_dst = D
  always_comb begin
    case (alpha_mode)
      MODE_ONE: begin
        wt.div_sel = DIV_1;
        wt.w_src   = {7'd0, alpha_q[0]};
        wt.w_dst   = {7'd0, ~alpha_q[0]};
      end
      MODE_TWO: begin
        wt.div_sel = DIV_3;
        wt.w_src   = {6'd0, alpha_q[1:0]};
        wt.w_dst   = {6'd0, ~alpha_q[1:0]};
      end
      MODE_FOUR: begin
        wt.div_sel = DIV_15;
        wt.w_src   = {4'd0, alpha_q[3:0]};
        wt.w_dst   = {4'd0, ~alpha_q[3:0]};
      end
      MODE_EIGHT: begin
        wt.div_sel = DIV_255;
        wt.w_src   = alpha_q;
        wt.w_dst   = ~alpha_q;
      end
      default: begin
        wt.div_sel = DIV_1;
        wt.w_src   = 8'd1;
        wt.w_dst   = 8'd0;
      end
    endcase
  end

  rgbab_chan u_c0 (
    .s_i   (1'b0),
    .wt_i  (wt),
    .src_i ({1'b0, src_q[4:0]}),
    .dst_i ({1'b0, dst_q[4:0]}),
    .y_o   (c0)
  );

  rgbab_chan u_c1 (
    .s_i   (1'b1),
    .wt_i  (wt),
    .src_i (src_q[10:5]),
    .dst_i (dst_q[10:5]),
    .y_o   (c1)
  );

  rgbab_chan u_c2 (
    .s_i   (1'b0),
    .wt_i  (wt),
    .src_i ({1'b0, src_q[15:11]}),
    .dst_i ({1'b0, dst_q[15:11]}),
    .y_o   (c2)
  );

  assign out_d          = {c2[4:0], c1, c0[4:0]};
  assign result_valid_o = out_vld_q;
  assign out_pixel_o    = out_q;

endmodule

`default_nettype wire

[rtl/core/rgbab_cfg.sv]
`default_nettype none

module rgbab_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rgbab_pkg::AddrW-1:0] paddr,
  input  wire logic [rgbab_pkg::DataW-1:0] pwdata,
  output logic      [rgbab_pkg::DataW-1:0] prdata,
  output logic                             pready,
  output logic      [rgbab_pkg::ModeW-1:0] alpha_mode_o
);
  import rgbab_pkg::*;

  logic [ModeW-1:0] mode_q, mode_d;
  logic             hit;

  assign hit = (paddr[AddrW-1] == ADDR_ALPHA_MODE[AddrW-1]);

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && hit) begin
      mode_d = pwdata[ModeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OPAQUE;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata       = hit ? {{(DataW-ModeW){1'b0}}, mode_q} : '0;
  assign pready       = 1'b1;
  assign alpha_mode_o = mode_q;

endmodule

`default_nettype wire

[rtl/core/rgbab_chan.sv]
`default_nettype none

module rgbab_chan (
  input  wire logic                        s_i,
  input  wire rgbab_pkg::weight_t          wt_i,
  input  wire logic [rgbab_pkg::ChanW-1:0] src_i,
  input  wire logic [rgbab_pkg::ChanW-1:0] dst_i,
  output logic      [rgbab_pkg::ChanW-1:0] y_o
);
  import rgbab_pkg::*;

  logic [ProdW-1:0] ps, pd;
  logic [ChanW-1:0] qs, qd;
  logic [ChanW-1:0] sum;

  assign ps = {{WtW{1'b0}}, src_i} * {{ChanW{1'b0}}, wt_i.w_src};
  assign pd = {{WtW{1'b0}}, dst_i} * {{ChanW{1'b0}}, wt_i.w_dst};

  always_comb begin
    case (wt_i.div_sel)
      DIV_1: begin
        qs = ps[ChanW-1:0];
        qd = pd[ChanW-1:0];
      end
      DIV_3: begin
        qs = div3(ps);
        qd = div3(pd);
      end
      DIV_15: begin
        qs = div15(ps);
        qd = div15(pd);
      end
      DIV_255: begin
        qs = div255(ps);
        qd = div255(pd);
      end
      default: begin
        qs = src_i;
        qd = '0;
      end
    endcase
  end

  // floored terms never sum past the channel maximum
  assign sum = qs + qd;
  // 5-bit channels use the low bits only
  assign y_o = s_i ? sum : {1'b0, sum[ChanW-2:0]};

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rgbab_pkg::*;

  localparam logic [AddrW-1:0] ADDR_UNUSED     = 3'd4;
  localparam logic [ModeW-1:0] MODE_UNUSED_5   = 3'd5;
  localparam logic [ModeW-1:0] MODE_UNUSED_6   = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNUSED_7   = 3'd7;
  localparam int unsigned      STALL_LIMIT     = 500;
  localparam int unsigned      NUM_PHASES      = 12;
  localparam int unsigned      PIXELS_PER_PHASE = 140;

  class blend_scoreboard;
    logic [PixW-1:0]  expected_q[$];
    logic [ModeW-1:0] alpha_mode;
    int unsigned      errors;
    int unsigned      pixels_in;
    int unsigned      pixels_out;

    function new();
      alpha_mode = MODE_OPAQUE;
      errors     = 0;
      pixels_in  = 0;
      pixels_out = 0;
    endfunction

    function automatic int unsigned weigh_channel(int unsigned s, int unsigned d,
                                                  int unsigned w, int unsigned den,
                                                  int unsigned maxv);
      int unsigned r;
      r = (s * w) / den + (d * (den - w)) / den;
      return (r > maxv) ? maxv : r;
    endfunction

    function automatic logic [PixW-1:0] mix_pixel(logic [PixW-1:0] s, logic [PixW-1:0] d,
                                                  int unsigned w, int unsigned den);
      logic [4:0] c0;
      logic [5:0] c1;
      logic [4:0] c2;
      c0 = 5'(weigh_channel(32'(s[4:0]), 32'(d[4:0]), w, den, 31));
      c1 = 6'(weigh_channel(32'(s[10:5]), 32'(d[10:5]), w, den, 63));
      c2 = 5'(weigh_channel(32'(s[15:11]), 32'(d[15:11]), w, den, 31));
      return {c2, c1, c0};
    endfunction

    function automatic logic [PixW-1:0] blend_pixel(logic [PixW-1:0] s, logic [PixW-1:0] d,
                                                    logic [AlphaW-1:0] a);
      case (alpha_mode)
        MODE_ONE: begin
          return a[0] ? s : d;
        end
        MODE_TWO: begin
          case (a[1:0])
            2'd0:    return d;
            2'd1:    return mix_pixel(s, d, 1, 3);
            2'd2:    return mix_pixel(s, d, 2, 3);
            default: return s;
          endcase
        end
        MODE_FOUR: begin
          return mix_pixel(s, d, 32'(a[3:0]), 15);
        end
        MODE_EIGHT: begin
          return mix_pixel(s, d, 32'(a), 255);
        end
        default: begin
          return s;
        end
      endcase
    endfunction

    function void note_pixel(logic [PixW-1:0] s, logic [PixW-1:0] d, logic [AlphaW-1:0] a);
      expected_q.push_back(blend_pixel(s, d, a));
      pixels_in++;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(logic [PixW-1:0] got);
      logic [PixW-1:0] want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_pixel=%04h", got));
      end else begin
        want = expected_q.pop_front();
        pixels_out++;
        if (got !== want) begin
          report_mismatch($sformatf("out_pixel=%04h, predicted %04h", got, want));
        end
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [PixW-1:0]   src_pixel_i = '0;
  logic [PixW-1:0]   dst_pixel_i = '0;
  logic [AlphaW-1:0] alpha_i = '0;
  logic              result_valid_o;
  logic [PixW-1:0]   out_pixel_o;

  blend_scoreboard   sb = new();
  int unsigned       stall_cycles = 0;
  int unsigned       mode_writes = 0;

  always #4 clk_i = ~clk_i;

  rgb565_alpha_blend_pixel_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .src_pixel_i    (src_pixel_i),
    .dst_pixel_i    (dst_pixel_i),
    .alpha_i        (alpha_i),
    .result_valid_o (result_valid_o),
    .out_pixel_o    (out_pixel_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_pixel(out_pixel_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task send_pixel(input logic [PixW-1:0] s, input logic [PixW-1:0] d,
                  input logic [AlphaW-1:0] a);
    start       <= 1'b1;
    src_pixel_i <= s;
    dst_pixel_i <= d;
    alpha_i     <= a;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(s, d, a);
  endtask

  task pause_stream(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task drain;
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ALPHA_MODE) begin
      sb.alpha_mode = data[ModeW-1:0];
    end
    @(posedge clk_i);
  endtask

  task apb_check_mode;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ALPHA_MODE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[ModeW-1:0] !== sb.alpha_mode) begin
      sb.report_mismatch($sformatf("alpha_mode read %0d, written %0d",
                                   prdata[ModeW-1:0], sb.alpha_mode));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits are noise; only the mode bits land in the register
  task set_mode(input logic [ModeW-1:0] m);
    logic [DataW-1:0] data;
    drain();
    data = $urandom();
    data[ModeW-1:0] = m;
    apb_write(ADDR_ALPHA_MODE, data);
    mode_writes++;
    apb_check_mode();
  endtask

  function automatic int unsigned pick_chan(int unsigned maxv);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return maxv;
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    logic [PixW-1:0] p;
    if ($urandom_range(0, 3) == 0) begin
      p[4:0]   = 5'(pick_chan(31));
      p[10:5]  = 6'(pick_chan(63));
      p[15:11] = 5'(pick_chan(31));
    end else begin
      p = 16'($urandom());
    end
    return p;
  endfunction

  function automatic logic [AlphaW-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return {4'($urandom()), 4'hF};
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    logic [ModeW-1:0] phase_modes[NUM_PHASES];
    int unsigned      stretch;
    bit               gaps_on;

    phase_modes = '{MODE_EIGHT, MODE_FOUR, MODE_TWO, MODE_ONE, MODE_OPAQUE, MODE_UNUSED_7,
                    MODE_EIGHT, MODE_FOUR, MODE_TWO, MODE_EIGHT, MODE_FOUR, MODE_TWO};
    stretch = 0;
    gaps_on = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset mode is opaque copy
    apb_check_mode();
    send_pixel(16'hFFFF, 16'h0000, 8'h00);
    send_pixel(16'h0000, 16'hFFFF, 8'hFF);

    set_mode(MODE_ONE);
    send_pixel(16'hFFFF, 16'h0000, 8'h01);
    send_pixel(16'hFFFF, 16'h0000, 8'hFE);

    set_mode(MODE_TWO);
    send_pixel(16'hFFFF, 16'h0000, 8'h00);
    send_pixel(16'hFFFF, 16'h0000, 8'h01);
    send_pixel(16'hFFFF, 16'h0000, 8'h02);
    send_pixel(16'h0000, 16'hFFFF, 8'h01);
    send_pixel(16'hFFFF, 16'h0000, 8'hFF);

    set_mode(MODE_FOUR);
    send_pixel(16'hFFFF, 16'h0000, 8'hF0);
    send_pixel(16'hFFFF, 16'h0000, 8'h0F);
    send_pixel(16'h0000, 16'hFFFF, 8'h07);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h08);

    set_mode(MODE_EIGHT);
    send_pixel(16'hFFFF, 16'h0000, 8'h00);
    send_pixel(16'hFFFF, 16'h0000, 8'hFF);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h80);

    // write to an address with no register must leave the mode alone
    drain();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFF9);
    apb_check_mode();
    send_pixel(16'h1234, 16'hFEDC, 8'h40);

    set_mode(MODE_UNUSED_5);
    send_pixel(16'hA5A5, 16'h5A5A, 8'h81);
    set_mode(MODE_UNUSED_6);
    send_pixel(16'h5A5A, 16'hA5A5, 8'h42);

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_mode((ph == 9) ? 3'($urandom_range(0, 7)) : phase_modes[ph]);
      if (ph == 5) begin
        drain();
        apb_write(ADDR_UNUSED, $urandom());
        apb_check_mode();
      end
      for (int unsigned i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel(pick_pixel(), pick_pixel(), pick_alpha());
        if (stretch == 0) begin
          gaps_on = ($urandom_range(0, 2) != 0);
          stretch = $urandom_range(20, 60);
        end
        stretch--;
        if (ph < NUM_PHASES - 2 && gaps_on && $urandom_range(0, 4) == 0) begin
          pause_stream($urandom_range(1, 17));
        end
      end
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("Blended %0d pixels across %0d alpha mode writes, all eight mode codes",
             sb.pixels_in, mode_writes);
    $display("Checked %0d results, %0d mismatches, %0d left outstanding",
             sb.pixels_out, sb.errors, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
